// ----- design/grs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grs_pkg: shared types and constants for the gain reduction ramp smoother
// widths of the gain and window fields, and the divider operand widths
// ---------------------------------------------------------------------------
package grs_pkg;

	localparam int GAIN_W  = 24;            // signed q8.16 gain
	localparam int COUNT_W = 16;            // window length and position
	localparam int DIFF_W  = GAIN_W + 1;    // exact target minus held

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic [COUNT_W-1:0]       count_t;
	typedef logic [DIFF_W-1:0]        diff_t;

endpackage

// ----- design/grs_ifs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grs interfaces: valid/ready channels of the ramp smoother
// sample input, smoothed gain output and the window length write channel
// ---------------------------------------------------------------------------
interface grs_in_if
	import grs_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  mode;
	gain_t gain_value;

	modport source (output valid, output mode, output gain_value, input ready);
	modport sink   (input valid, input mode, input gain_value, output ready);
endinterface

interface grs_out_if
	import grs_pkg::*;
();
	logic  valid;
	logic  ready;
	gain_t smoothed_gain;

	modport source (output valid, output smoothed_gain, input ready);
	modport sink   (input valid, input smoothed_gain, output ready);
endinterface

interface grs_cfg_if
	import grs_pkg::*;
();
	logic   valid;
	logic   ready;
	count_t transition_samples;

	modport source (output valid, output transition_samples, input ready);
	modport sink   (input valid, input transition_samples, output ready);
endinterface

// ----- design/grs_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grs_div: bit-serial restoring divider
// unsigned num / den, one quotient bit per cycle, done pulses when finished
// ---------------------------------------------------------------------------
module grs_div
	import grs_pkg::*;
#(
	parameter int NUM_W = DIFF_W,
	parameter int DEN_W = COUNT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

	logic             running_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             qbit;

	// next partial remainder candidate and its trial subtraction
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign qbit    = ~trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_LOAD;
			end else if (running_q) begin
				cnt_q <= cnt_q - CNT_LAST;
				if (cnt_q == CNT_LAST) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (running_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/gain_reduction_ramp_smoother.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gain_reduction_ramp_smoother: linear ramp toward a target gain reduction
// each sample item moves the held q8.16 gain by (target - held) / samples left
// ---------------------------------------------------------------------------
// one item at a time: a sample item goes through the prepare step, the
// bit-serial divider for the 25-bit difference (25 shifts, then a done step),
// the step addition and the commit into the output register; a load item or
// a zero window skips the divider and goes from prepare straight to commit.
// a new item is taken the cycle after the previous one has committed, even
// while its result still waits in the output register; a waiting result that
// has not yet been taken holds up the commit.
// transition_samples is the window length; it is written through cfg, which is
// always ready, and must only be written while the block is idle.
module gain_reduction_ramp_smoother
	import grs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	grs_cfg_if.sink  cfg,
	grs_in_if.sink   sample_in,
	grs_out_if.source sample_out
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;

	// architectural state
	count_t ts_q;          // window length
	gain_t  held_q;        // held gain reduction
	count_t count_q;       // position in the window

	// per item working registers
	logic   mode_q;
	gain_t  target_q;
	logic   neg_q;
	gain_t  new_held_q;
	count_t new_count_q;

	// output register
	logic   out_valid_q;
	gain_t  out_gain_q;

	logic   in_fire;
	logic   commit;
	logic   direct;
	logic   div_start;
	logic   div_done;
	diff_t  div_quo;

	diff_t  diff;
	diff_t  mag;
	count_t cnt_eff;
	count_t left;
	logic [COUNT_W:0] cnt_inc;
	count_t cnt_next;
	diff_t  step;

	assign cfg.ready       = 1'b1;
	assign sample_in.ready = (state_q == ST_IDLE);
	assign in_fire         = sample_in.valid && sample_in.ready;

	// result moves into the output register once the previous one is gone
	assign commit = (state_q == ST_DONE) && (!out_valid_q || sample_out.ready);

	// load items and a zero window take the value straight through
	assign direct = mode_q || (ts_q == '0);

	// exact difference and its magnitude for the divider
	assign diff = {target_q[GAIN_W-1], target_q} - {held_q[GAIN_W-1], held_q};
	assign mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

	// a count left at or past a shortened window restarts at zero
	assign cnt_eff  = (count_q >= ts_q) ? '0 : count_q;
	assign left     = ts_q - cnt_eff;
	assign cnt_inc  = {1'b0, cnt_eff} + {{COUNT_W{1'b0}}, 1'b1};
	assign cnt_next = (cnt_inc >= {1'b0, ts_q}) ? '0 : cnt_inc[COUNT_W-1:0];

	assign div_start = (state_q == ST_PREP) && !direct;

	// quotient magnitude back to a signed step, truncated toward zero
	assign step = neg_q ? (~div_quo + DIFF_W'(1)) : div_quo;

	grs_div #(
		.NUM_W (DIFF_W),
		.DEN_W (COUNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (mag),
		.den      (left),
		.done     (div_done),
		.quotient (div_quo)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= '0;
		end else if (cfg.valid) begin
			ts_q <= cfg.transition_samples;
		end
	end

	// sequencer, held state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_out.ready && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= direct ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit) begin
						held_q      <= new_held_q;
						count_q     <= new_count_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and intermediate results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q   <= sample_in.mode;
			target_q <= sample_in.gain_value;
		end
		if (state_q == ST_PREP) begin
			neg_q <= diff[DIFF_W-1];
			if (direct) begin
				new_held_q  <= target_q;
				new_count_q <= '0;
			end else begin
				new_count_q <= cnt_next;
			end
		end
		if (state_q == ST_FIN) begin
			new_held_q <= held_q + step[GAIN_W-1:0];
		end
		if (commit) begin
			out_gain_q <= new_held_q;
		end
	end

	assign sample_out.valid         = out_valid_q;
	assign sample_out.smoothed_gain = out_gain_q;

`ifndef NO_ASSERTIONS
	// a result only appears from the commit step
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result appeared outside commit");

	// the divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	// held gain changes only at commit
	a_held_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_q) |-> $past(commit))
		else $error("held gain changed without commit");

	// a committed item leaves its result in the output register
	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && out_gain_q == held_q)
		else $error("committed result lost");
`endif

endmodule
